[rtl/core/pcse_pkg.sv]
`default_nettype none

package pcse_pkg;

	// coordinate words are opaque and pass straight through
	localparam int WordW = 32;

	// result queue, deep enough to take a two-result point without overflowing
	localparam int FifoDepth = 4;
	localparam int PtrW = $clog2(FifoDepth);
	localparam int CntW = PtrW + 1;

	// input point tags
	localparam logic [1:0] PK_ON = 2'd0;
	localparam logic [1:0] PK_CA = 2'd1;
	localparam logic [1:0] PK_CB = 2'd2;

	typedef enum logic [2:0] {
		PH_EMPTY = 3'd0,
		PH_ON    = 3'd1,
		PH_CA    = 3'd2,
		PH_CB    = 3'd3,
		PH_DEAD  = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		SK_LINE  = 2'd0,
		SK_QUAD  = 2'd1,
		SK_CUBIC = 2'd2,
		SK_ERROR = 2'd3
	} seg_kind_t;

	typedef struct packed {
		seg_kind_t         kind;
		logic [WordW-1:0]  from_x;
		logic [WordW-1:0]  from_y;
		logic [WordW-1:0]  ca_x;
		logic [WordW-1:0]  ca_y;
		logic [WordW-1:0]  cb_x;
		logic [WordW-1:0]  cb_y;
		logic [WordW-1:0]  to_x;
		logic [WordW-1:0]  to_y;
		logic              closes;
		logic              last;
	} seg_rec_t;

	localparam seg_rec_t SEG_NONE = '{
		kind: SK_ERROR, from_x: '0, from_y: '0, ca_x: '0, ca_y: '0,
		cb_x: '0, cb_y: '0, to_x: '0, to_y: '0, closes: 1'b0, last: 1'b0
	};

endpackage

`default_nettype wire

[rtl/core/path_contour_segment_extractor_core.sv]
`default_nettype none

// Contour segment extractor.
// Point channel (point_valid / point_stall): one contour point per transfer,
// tagged on-curve, first control or second control, with end_of_contour on
// the contour's last point. Segment channel (seg_valid / seg_stall): line,
// quadratic and cubic segments, a closing line marked closes_contour, or a
// malformed-contour marker (seg_kind 3). last_of_run flags the final result
// caused by a point. Config channel (cfg_valid / cfg_ready): force_close,
// always ready; write only while the block is idle.
// A result is queued the cycle after its point transfers and is presented
// once earlier results drain. Throughput: one point per cycle while
// point_stall is low. Results drain through a four-entry queue at one per
// cycle while seg_stall is low; a two-result point (segment plus closing
// line) queues both. point_stall rises while three or more are queued.
// Reset: queue empty, awaiting a contour's first point, force_close cleared.
// A stalled receiver holds the head result steady; the queue fills and then
// stalls the point side.

module path_contour_segment_extractor_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        force_close,
	input  logic        point_valid,
	output logic        point_stall,
	input  logic [31:0] point_x,
	input  logic [31:0] point_y,
	input  logic [1:0]  point_kind,
	input  logic        end_of_contour,
	input  logic        contour_closed,
	output logic        seg_valid,
	input  logic        seg_stall,
	output logic [1:0]  seg_kind,
	output logic [31:0] from_x,
	output logic [31:0] from_y,
	output logic [31:0] ctrl_a_x,
	output logic [31:0] ctrl_a_y,
	output logic [31:0] ctrl_b_x,
	output logic [31:0] ctrl_b_y,
	output logic [31:0] to_x,
	output logic [31:0] to_y,
	output logic        closes_contour,
	output logic        last_of_run
);

	// contour state
	logic                         force_close_q;
	logic [pcse_pkg::WordW-1:0]   first_x_q, first_y_q;
	logic [pcse_pkg::WordW-1:0]   start_x_q, start_y_q;
	logic [2*pcse_pkg::WordW-1:0] held_a_q, held_b_q;
	pcse_pkg::phase_t             phase_q;
	logic                         more_q;

	logic [pcse_pkg::WordW-1:0]   first_x_n, first_y_n;
	logic [pcse_pkg::WordW-1:0]   start_x_n, start_y_n;
	logic [2*pcse_pkg::WordW-1:0] held_a_n, held_b_n;
	pcse_pkg::phase_t             phase_n;
	logic                         more_n;

	// results of the current point
	pcse_pkg::seg_rec_t seg_r, tail_r, first_r;
	logic               seg_v, tail_v;
	logic [1:0]         n_res;

	// result queue
	pcse_pkg::seg_rec_t             fifo_q [pcse_pkg::FifoDepth];
	logic [pcse_pkg::PtrW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [pcse_pkg::CntW-1:0]      cnt_q;
	pcse_pkg::seg_rec_t             head;
	logic                           take, pop;

	assign cfg_ready   = 1'b1;
	assign take        = point_valid && !point_stall;
	assign pop         = seg_valid && !seg_stall;
	assign point_stall = cnt_q > pcse_pkg::CntW'(pcse_pkg::FifoDepth - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_close_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			force_close_q <= force_close;
		end
	end

	// segment grouping for one point
	always_comb begin
		first_x_n = first_x_q;
		first_y_n = first_y_q;
		start_x_n = start_x_q;
		start_y_n = start_y_q;
		held_a_n  = held_a_q;
		held_b_n  = held_b_q;
		phase_n   = phase_q;
		more_n    = more_q;
		seg_r     = pcse_pkg::SEG_NONE;
		tail_r    = pcse_pkg::SEG_NONE;
		seg_v     = 1'b0;
		tail_v    = 1'b0;

		unique case (phase_q)
			pcse_pkg::PH_ON: begin
				more_n = 1'b1;
				case (point_kind)
					pcse_pkg::PK_ON: begin
						seg_v       = 1'b1;
						seg_r.kind  = pcse_pkg::SK_LINE;
						seg_r.from_x = start_x_q;
						seg_r.from_y = start_y_q;
						seg_r.to_x  = point_x;
						seg_r.to_y  = point_y;
						start_x_n   = point_x;
						start_y_n   = point_y;
					end
					pcse_pkg::PK_CA: begin
						held_a_n = {point_y, point_x};
						phase_n  = pcse_pkg::PH_CA;
					end
					default: begin
						seg_v   = 1'b1;
						phase_n = pcse_pkg::PH_DEAD;
					end
				endcase
			end
			pcse_pkg::PH_CA: begin
				more_n = 1'b1;
				case (point_kind)
					pcse_pkg::PK_ON: begin
						seg_v        = 1'b1;
						seg_r.kind   = pcse_pkg::SK_QUAD;
						seg_r.from_x = start_x_q;
						seg_r.from_y = start_y_q;
						seg_r.ca_x   = held_a_q[pcse_pkg::WordW-1:0];
						seg_r.ca_y   = held_a_q[2*pcse_pkg::WordW-1:pcse_pkg::WordW];
						seg_r.to_x   = point_x;
						seg_r.to_y   = point_y;
						start_x_n    = point_x;
						start_y_n    = point_y;
						phase_n      = pcse_pkg::PH_ON;
					end
					pcse_pkg::PK_CB: begin
						held_b_n = {point_y, point_x};
						phase_n  = pcse_pkg::PH_CB;
					end
					default: begin
						seg_v   = 1'b1;
						phase_n = pcse_pkg::PH_DEAD;
					end
				endcase
			end
			pcse_pkg::PH_CB: begin
				more_n = 1'b1;
				if (point_kind == pcse_pkg::PK_ON) begin
					seg_v        = 1'b1;
					seg_r.kind   = pcse_pkg::SK_CUBIC;
					seg_r.from_x = start_x_q;
					seg_r.from_y = start_y_q;
					seg_r.ca_x   = held_a_q[pcse_pkg::WordW-1:0];
					seg_r.ca_y   = held_a_q[2*pcse_pkg::WordW-1:pcse_pkg::WordW];
					seg_r.cb_x   = held_b_q[pcse_pkg::WordW-1:0];
					seg_r.cb_y   = held_b_q[2*pcse_pkg::WordW-1:pcse_pkg::WordW];
					seg_r.to_x   = point_x;
					seg_r.to_y   = point_y;
					start_x_n    = point_x;
					start_y_n    = point_y;
					phase_n      = pcse_pkg::PH_ON;
				end else begin
					seg_v   = 1'b1;
					phase_n = pcse_pkg::PH_DEAD;
				end
			end
			pcse_pkg::PH_DEAD: begin
			end
			default: begin
				// first point of a contour
				more_n = 1'b0;
				if (point_kind == pcse_pkg::PK_ON) begin
					first_x_n = point_x;
					first_y_n = point_y;
					start_x_n = point_x;
					start_y_n = point_y;
					phase_n   = pcse_pkg::PH_ON;
				end else begin
					seg_v   = 1'b1;
					phase_n = pcse_pkg::PH_DEAD;
				end
			end
		endcase

		if (end_of_contour) begin
			if (phase_n == pcse_pkg::PH_ON) begin
				if ((contour_closed || force_close_q) && more_n) begin
					tail_v        = 1'b1;
					tail_r.kind   = pcse_pkg::SK_LINE;
					tail_r.from_x = start_x_n;
					tail_r.from_y = start_y_n;
					tail_r.to_x   = first_x_n;
					tail_r.to_y   = first_y_n;
					tail_r.closes = 1'b1;
				end
			end else if (phase_n == pcse_pkg::PH_CA || phase_n == pcse_pkg::PH_CB) begin
				// trailing control points
				tail_v = 1'b1;
			end
			phase_n = pcse_pkg::PH_EMPTY;
			more_n  = 1'b0;
		end

		n_res       = {1'b0, seg_v} + {1'b0, tail_v};
		first_r     = seg_v ? seg_r : tail_r;
		first_r.last = (n_res == 2'd1);
		tail_r.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q <= '0;
			first_y_q <= '0;
			start_x_q <= '0;
			start_y_q <= '0;
			held_a_q  <= '0;
			held_b_q  <= '0;
			phase_q   <= pcse_pkg::PH_EMPTY;
			more_q    <= 1'b0;
		end else if (take) begin
			first_x_q <= first_x_n;
			first_y_q <= first_y_n;
			start_x_q <= start_x_n;
			start_y_q <= start_y_n;
			held_a_q  <= held_a_n;
			held_b_q  <= held_b_n;
			phase_q   <= phase_n;
			more_q    <= more_n;
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (take && n_res != 2'd0) begin
			fifo_q[wr_ptr_q] <= first_r;
		end
		if (take && n_res == 2'd2) begin
			fifo_q[pcse_pkg::PtrW'(wr_ptr_q + 1'b1)] <= tail_r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (take) begin
				wr_ptr_q <= pcse_pkg::PtrW'(wr_ptr_q + n_res);
			end
			if (pop) begin
				rd_ptr_q <= pcse_pkg::PtrW'(rd_ptr_q + 1'b1);
			end
			cnt_q <= pcse_pkg::CntW'(cnt_q + (take ? pcse_pkg::CntW'(n_res) : '0)
				- (pop ? pcse_pkg::CntW'(1) : '0));
		end
	end

	assign head           = fifo_q[rd_ptr_q];
	assign seg_valid      = cnt_q != '0;
	assign seg_kind       = head.kind;
	assign from_x         = head.from_x;
	assign from_y         = head.from_y;
	assign ctrl_a_x       = head.ca_x;
	assign ctrl_a_y       = head.ca_y;
	assign ctrl_b_x       = head.cb_x;
	assign ctrl_b_y       = head.cb_y;
	assign to_x           = head.to_x;
	assign to_y           = head.to_y;
	assign closes_contour = head.closes;
	assign last_of_run    = head.last;

	// queue never overfills
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= pcse_pkg::CntW'(pcse_pkg::FifoDepth))
		else $error("result queue overflow");

	// a contour's last point always rearms the grouping
	a_eoc_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		take && end_of_contour |=> phase_q == pcse_pkg::PH_EMPTY)
		else $error("phase not cleared after end of contour");

	// closing line is a line and ends its run
	a_close_line: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && closes_contour |-> seg_kind == pcse_pkg::SK_LINE && last_of_run)
		else $error("closing line malformed");

	// error marker carries no coordinates
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		seg_valid && seg_kind == pcse_pkg::SK_ERROR |->
			from_x == '0 && to_y == '0 && ctrl_a_x == '0 && ctrl_b_y == '0 && !closes_contour)
		else $error("error result carries data");

endmodule

`default_nettype wire
